// ===== rtl/email_address_syntax_check_unit_defines.svh =====
// assertion macros shared by the email address syntax check unit
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef EMAIL_ADDRESS_SYNTAX_CHECK_UNIT_DEFINES_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECK_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EASC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define EASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/easc_pkg.sv =====
// types and constants of the email address syntax check unit
// no dependencies
package easc_pkg;

  localparam int unsigned EASC_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_USCORE  = 8'h5f;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;

  // character classes seen by the back end
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_AT,
    CLS_DOT,
    CLS_DASH,
    CLS_ALNUM,
    CLS_SYM,
    CLS_BAD
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic        last;
  } token_t;

endpackage

// ===== rtl/easc_in_if.sv =====
// input channel of the email address syntax check unit
// no dependencies
interface easc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_present;
  logic       string_end;

  modport source (output valid, output char_byte, output char_present,
                  output string_end, input ready);
  modport sink (input valid, input char_byte, input char_present,
                input string_end, output ready);
endinterface

// ===== rtl/easc_out_if.sv =====
// result channel of the email address syntax check unit
// no dependencies
interface easc_out_if;
  logic valid;
  logic ready;
  logic address_ok;

  modport source (output valid, output address_ok, input ready);
  modport sink (input valid, input address_ok, output ready);
endinterface

// ===== rtl/easc_front.sv =====
// front end: accepts input beats and classifies the character
// depends on easc_pkg and easc_in_if
module easc_front (
  easc_in_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output easc_pkg::token_t  token_o
);
  import easc_pkg::*;

  logic        is_digit;
  logic        is_upper;
  logic        is_lower;
  char_class_e cls;

  assign is_digit = (in_i.char_byte >= 8'h30) && (in_i.char_byte <= 8'h39);
  assign is_upper = (in_i.char_byte >= 8'h41) && (in_i.char_byte <= 8'h5a);
  assign is_lower = (in_i.char_byte >= 8'h61) && (in_i.char_byte <= 8'h7a);

  always_comb begin
    if (!in_i.char_present) begin
      cls = CLS_NONE;
    end else if (in_i.char_byte == CH_AT) begin
      cls = CLS_AT;
    end else if (in_i.char_byte == CH_DOT) begin
      cls = CLS_DOT;
    end else if (in_i.char_byte == CH_DASH) begin
      cls = CLS_DASH;
    end else if (is_digit || is_upper || is_lower) begin
      cls = CLS_ALNUM;
    end else if ((in_i.char_byte == CH_USCORE) || (in_i.char_byte == CH_PERCENT) ||
                 (in_i.char_byte == CH_PLUS)) begin
      cls = CLS_SYM;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign in_i.ready   = !full_i;
  assign token_o.cls  = cls;
  assign token_o.last = in_i.string_end;
  // idle beats change nothing, so they are taken and dropped here
  assign push_o = in_i.valid && !full_i && (in_i.char_present || in_i.string_end);

endmodule

// ===== rtl/easc_queue.sv =====
// short token queue between front and back end
// depends on easc_pkg
module easc_queue #(
  parameter int unsigned Depth = easc_pkg::EASC_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  easc_pkg::token_t  token_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output easc_pkg::token_t  token_o
);
  import easc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  token_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign token_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

// ===== rtl/easc_back.sv =====
// back end: applies the syntax rules per token and registers the result
// depends on easc_pkg, easc_out_if and the assertion macro header
`include "email_address_syntax_check_unit_defines.svh"
module easc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  easc_pkg::token_t  token_i,
  output logic              pop_o,
  easc_out_if.source        out_o
);
  import easc_pkg::*;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DOT,
    KIND_DASH,
    KIND_OTHER
  } kind_e;

  logic  at_q, at_d;
  logic  fail_q, fail_d;
  logic  dot_q, dot_d;
  kind_e kind_q, kind_d;
  logic  out_valid_q, out_valid_d;
  logic  ok_q, ok_d;
  logic  done;

  // a closing token may only leave when the result slot frees up
  assign pop_o = valid_i && (!token_i.last || !out_valid_q || out_o.ready);
  assign done  = pop_o && token_i.last;

  always_comb begin
    at_d   = at_q;
    fail_d = fail_q;
    dot_d  = dot_q;
    kind_d = kind_q;
    if (pop_o) begin
      case (token_i.cls)
        CLS_NONE: begin
        end
        CLS_AT: begin
          if (at_q || (kind_q != KIND_OTHER)) fail_d = 1'b1;
          at_d   = 1'b1;
          kind_d = KIND_START;
        end
        CLS_DOT: begin
          if (!at_q) begin
            if ((kind_q == KIND_START) || (kind_q == KIND_DOT)) fail_d = 1'b1;
          end else begin
            if (kind_q != KIND_OTHER) fail_d = 1'b1;
            dot_d = 1'b1;
          end
          kind_d = KIND_DOT;
        end
        CLS_DASH: begin
          if ((kind_q == KIND_START) || (at_q && (kind_q == KIND_DOT))) fail_d = 1'b1;
          kind_d = KIND_DASH;
        end
        CLS_ALNUM: begin
          kind_d = KIND_OTHER;
        end
        CLS_SYM: begin
          // _ % + are local part only
          if (at_q) fail_d = 1'b1;
          kind_d = KIND_OTHER;
        end
        default: begin
          fail_d = 1'b1;
          kind_d = KIND_OTHER;
        end
      endcase
    end
    ok_d        = ok_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (done) begin
      ok_d        = !fail_d && at_d && (kind_d == KIND_OTHER) && dot_d;
      out_valid_d = 1'b1;
      at_d        = 1'b0;
      fail_d      = 1'b0;
      dot_d       = 1'b0;
      kind_d      = KIND_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q        <= 1'b0;
      fail_q      <= 1'b0;
      dot_q       <= 1'b0;
      kind_q      <= KIND_START;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      at_q        <= at_d;
      fail_q      <= fail_d;
      dot_q       <= dot_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.address_ok = ok_q;

  `EASC_ASSERT_SAME(a_dot_needs_at, dot_q, at_q, "domain dot recorded before any at sign")
  `EASC_ASSERT_NEXT(a_clear_after_end, done,
    !at_q && !fail_q && !dot_q && (kind_q == KIND_START), "state not cleared after string end")
  `EASC_ASSERT_SAME(a_result_from_end, $rose(out_valid_q), $past(done),
    "result beat without a closing token")
  `EASC_ASSERT_NEXT(a_result_held, out_valid_q && !out_o.ready,
    out_valid_q && $stable(ok_q), "result dropped or changed while stalled")

endmodule

// ===== rtl/email_address_syntax_check_unit.sv =====
// result: a closing beat is written into the token queue, popped by the back end once the
// result slot is free, and its verdict is then registered together with result valid
// throughput: one input beat per cycle; while a result waits, beats flow on until a
// second closing beat reaches the back end, then the two-entry queue fills and input stalls
// reset: asynchronous, active low; clears queue, rule state and result valid
module email_address_syntax_check_unit #(
  parameter int unsigned QueueDepth = easc_pkg::EASC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  easc_in_if.sink     in_i,
  easc_out_if.source  out_o
);
  import easc_pkg::*;

  logic   push, full, pop, tok_valid;
  token_t tok_in, tok_out;

  easc_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .token_o (tok_in)
  );

  easc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (tok_valid),
    .token_o (tok_out)
  );

  easc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tok_valid),
    .token_i (tok_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/address_verdict_checker.sv =====
// checker for the email address syntax check unit: predicts the verdict of every string
// from the accepted input beats and compares it with each accepted result beat
// depends on easc_pkg and the easc_in_if / easc_out_if interfaces
module address_verdict_checker (
  input  logic clk_i,
  input  logic rst_ni,
  easc_in_if   in_mon,
  easc_out_if  out_mon,
  output int   mismatch_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import easc_pkg::*;

  // what the previous character of the current part was
  typedef enum logic [1:0] {
    POS_START,
    POS_DOT,
    POS_DASH,
    POS_OTHER
  } part_pos_e;

  logic      at_seen;
  logic      broken;
  logic      dom_dot;
  part_pos_e prev_pos;
  logic      verdict_q[$];
  int        mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_state();
    at_seen  = 1'b0;
    broken   = 1'b0;
    dom_dot  = 1'b0;
    prev_pos = POS_START;
  endfunction

  function automatic void predict_char(logic [7:0] c);
    if (c == CH_AT) begin
      // second '@', empty local part, or local part ends in '.' or '-'
      if (at_seen || prev_pos != POS_OTHER) broken = 1'b1;
      at_seen  = 1'b1;
      prev_pos = POS_START;
    end else if (!at_seen) begin
      if (c == CH_DOT) begin
        if (prev_pos == POS_START || prev_pos == POS_DOT) broken = 1'b1;
        prev_pos = POS_DOT;
      end else if (c == CH_DASH) begin
        if (prev_pos == POS_START) broken = 1'b1;
        prev_pos = POS_DASH;
      end else begin
        if (!(is_alnum(c) || c == CH_USCORE || c == CH_PERCENT || c == CH_PLUS)) broken = 1'b1;
        prev_pos = POS_OTHER;
      end
    end else begin
      if (c == CH_DOT) begin
        // leading dot, double dot, dash then dot
        if (prev_pos != POS_OTHER) broken = 1'b1;
        dom_dot  = 1'b1;
        prev_pos = POS_DOT;
      end else if (c == CH_DASH) begin
        if (prev_pos == POS_START || prev_pos == POS_DOT) broken = 1'b1;
        prev_pos = POS_DASH;
      end else begin
        if (!is_alnum(c)) broken = 1'b1;
        prev_pos = POS_OTHER;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic expected;
    if (!rst_ni) begin
      clear_state();
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      // result side first so a result can never match an expectation of the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("address_ok beat with no expected result: actual %0b", out_mon.address_ok);
          mismatches++;
        end else begin
          expected = verdict_q.pop_front();
          if (out_mon.address_ok !== expected) begin
            $error("address_ok mismatch: expected %0b, actual %0b", expected,
                   out_mon.address_ok);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.char_present) predict_char(in_mon.char_byte);
        if (in_mon.string_end) begin
          verdict_q.push_back(!broken && at_seen && prev_pos == POS_OTHER && dom_dot);
          clear_state();
        end
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the testbench for email_address_syntax_check_unit: clock, reset, address stimulus,
// result-side ready with a long hold-off, and the final verdict
// depends on easc_pkg, the channel interfaces and address_verdict_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import easc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned IDLE_PCT     = 33;
  localparam int unsigned GAP_BEAT_PCT = 6;
  localparam int unsigned SRC_BURST_LO = 500;
  localparam int unsigned SRC_BURST_HI = 700;
  localparam int unsigned HOLD_START   = 400;
  localparam int unsigned HOLD_LEN     = 120;
  localparam int unsigned SNK_BURST_LO = 900;
  localparam int unsigned SNK_BURST_HI = 1300;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 8;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          mismatch_cnt;
  int          pending_cnt;
  int unsigned item_cnt    = 0;
  bit          src_idle_on = 1'b1;
  logic [7:0]  text_q[$];

  easc_in_if  u_in ();
  easc_out_if u_out ();

  email_address_syntax_check_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (u_in),
    .out_o  (u_out)
  );

  address_verdict_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (u_in),
    .out_mon        (u_out),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  always #6 clk_i = ~clk_i;

  initial begin : run_limit
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(2))
      0: return "0" + 8'($urandom_range(9));
      1: return "A" + 8'($urandom_range(25));
      default: return "a" + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] pick_local_sym();
    case ($urandom_range(2))
      0: return CH_USCORE;
      1: return CH_PERCENT;
      default: return CH_PLUS;
    endcase
  endfunction

  // characters that tend to break the syntax rules
  function automatic logic [7:0] pick_troublesome();
    case ($urandom_range(5))
      0: return CH_AT;
      1: return CH_DOT;
      2: return CH_DASH;
      3: return pick_local_sym();
      4: return 8'($urandom_range(255));
      default: return pick_alnum();
    endcase
  endfunction

  function automatic void push_label(bit in_local);
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int unsigned j = 0; j < n; j++) begin
      if (j != 0 && j != n - 1 && $urandom_range(99) < 15) text_q.push_back(CH_DASH);
      else if (in_local && $urandom_range(99) < 20) text_q.push_back(pick_local_sym());
      else text_q.push_back(pick_alnum());
    end
  endfunction

  function automatic void make_address();
    int unsigned segs;
    text_q.delete();
    segs = $urandom_range(1, 3);
    for (int unsigned j = 0; j < segs; j++) begin
      if (j != 0) text_q.push_back(CH_DOT);
      push_label(1'b1);
    end
    text_q.push_back(CH_AT);
    segs = $urandom_range(2, 3);
    for (int unsigned j = 0; j < segs; j++) begin
      if (j != 0) text_q.push_back(CH_DOT);
      push_label(1'b0);
    end
  endfunction

  function automatic void make_random_text();
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 60) begin
      make_address();
    end else if (kind < 85) begin
      make_address();
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(3))
          0: text_q[pos] = pick_troublesome();
          1: text_q.insert(pos, pick_troublesome());
          2: if (text_q.size() > 1) text_q.delete(pos);
          default: text_q[pos] = 8'($urandom_range(255));
        endcase
      end
    end else begin
      // noise, possibly the empty string
      text_q.delete();
      repeat ($urandom_range(0, 8)) text_q.push_back(pick_troublesome());
    end
  endfunction

  function automatic void load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      u_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    u_in.valid        <= 1'b1;
    u_in.char_byte    <= b;
    u_in.char_present <= present;
    u_in.string_end   <= last;
    do begin
      @(posedge clk_i);
    end while (!u_in.ready);
    if (present || last) item_cnt++;
  endtask

  // sends text_q; a bare end marker closes it when asked or when the text is empty
  task automatic send_text(input bit bare_end);
    foreach (text_q[i]) begin
      if ($urandom_range(99) < GAP_BEAT_PCT) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, (i == text_q.size() - 1) && !bare_end);
    end
    if (bare_end || text_q.size() == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    u_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        // long hold-off so the block backs up into its input
        u_out.ready <= 1'b0;
      end else if (cyc >= SNK_BURST_LO && cyc < SNK_BURST_HI) begin
        u_out.ready <= 1'b1;
      end else begin
        u_out.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int unsigned guard;
    u_in.valid        <= 1'b0;
    u_in.char_byte    <= 8'h00;
    u_in.char_present <= 1'b0;
    u_in.string_end   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, then a minimal valid address closed by a bare end marker
    load_text("");
    send_text(1'b1);
    load_text("a@b.c");
    send_text(1'b1);
    // byte extremes as single-character strings
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    load_text("_%+@q.r");
    send_text(1'b0);
    load_text("x@y");
    send_text(1'b0);
    load_text("a@b.-c");
    send_text(1'b0);

    while (item_cnt < ITEM_TARGET) begin
      src_idle_on = !(item_cnt >= SRC_BURST_LO && item_cnt < SRC_BURST_HI);
      make_random_text();
      send_text($urandom_range(99) < 20);
    end
    u_in.valid <= 1'b0;
    // let the checker count the last accepted beat
    @(posedge clk_i);

    guard = 0;
    while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_cnt != 0) $error("%0d expected results never arrived", pending_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
